// ===== rtl/core/pipt_pkg.sv =====
// Package for the PI loop filter and phase tracker.
// Holds the microcode word, the datapath control bundle, register indexes
// and the control-store program. No dependencies.
package pipt_pkg;

    // Step counter width and the register map of the configuration port
    localparam int StepW = 3;
    localparam int CfgIdxW = 3;

    localparam logic [CfgIdxW-1:0] CFG_PROP_GAIN   = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_INTEG_GAIN  = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_UPPER_LIMIT = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_LOWER_LIMIT = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_TIME_STEP   = 3'd4;

    // Register reset values
    localparam logic [31:0] PROP_GAIN_RST   = 32'h0001_0000;
    localparam logic [31:0] INTEG_GAIN_RST  = 32'h0000_0000;
    localparam logic [31:0] UPPER_LIMIT_RST = 32'h0001_0000;
    localparam logic [31:0] LOWER_LIMIT_RST = 32'hFFFF_0000;
    localparam logic [31:0] TIME_STEP_RST   = 32'd429497;

    // 1.0 in Q16.16, added to the control output to form per-unit frequency
    localparam logic signed [33:0] ONE_Q16 = 34'sd65536;

    // Program steps
    localparam logic [StepW-1:0] ST_ACCEPT = 3'd0;
    localparam logic [StepW-1:0] ST_UP     = 3'd1;
    localparam logic [StepW-1:0] ST_INTEG  = 3'd2;
    localparam logic [StepW-1:0] ST_CLAMP  = 3'd3;
    localparam logic [StepW-1:0] ST_FREQ   = 3'd4;
    localparam logic [StepW-1:0] ST_SCALE  = 3'd5;
    localparam logic [StepW-1:0] ST_PHASE  = 3'd6;

    // Shared multiplier operand selects
    typedef enum logic [1:0] {
        MA_PROP  = 2'd0,
        MA_INTEG = 2'd1,
        MA_TSTEP = 2'd2
    } t_mul_a;

    typedef enum logic [1:0] {
        MB_ERR  = 2'd0,
        MB_UP   = 2'd1,
        MB_FREQ = 2'd2
    } t_mul_b;

    // One control word of the program
    typedef struct packed {
        t_mul_a mul_a;
        t_mul_b mul_b;
        logic   wait_in;   // hold here until an input transaction arrives
        logic   wait_out;  // hold here until the output register is free
        logic   last;      // jump back to the first step
        logic   ld_prod;
        logic   ld_up;
        logic   ld_integ;
        logic   ld_clamp;
        logic   ld_scale;
        logic   ld_out;
    } t_uop;

    // Enables actually applied to the datapath this cycle
    typedef struct packed {
        t_mul_a mul_a;
        t_mul_b mul_b;
        logic   ld_prod;
        logic   ld_up;
        logic   ld_integ;
        logic   ld_clamp;
        logic   ld_scale;
        logic   ld_out;
    } t_dp_ctl;

    // Control store
    function automatic t_uop ucode(input logic [StepW-1:0] step);
        t_uop w;
        w = '0;
        w.mul_a = MA_PROP;
        w.mul_b = MB_ERR;
        unique case (step)
            ST_ACCEPT: begin
                // prod = prop_gain * phase_error
                w.wait_in = 1'b1;
                w.ld_prod = 1'b1;
            end
            ST_UP: begin
                // latch up, prod = integ_gain * up
                w.mul_a   = MA_INTEG;
                w.mul_b   = MB_UP;
                w.ld_up   = 1'b1;
                w.ld_prod = 1'b1;
            end
            ST_INTEG: begin
                w.ld_integ = 1'b1;
            end
            ST_CLAMP: begin
                w.ld_clamp = 1'b1;
            end
            ST_FREQ: begin
                // prod = time_step * (control_out + 1.0)
                w.mul_a   = MA_TSTEP;
                w.mul_b   = MB_FREQ;
                w.ld_prod = 1'b1;
            end
            ST_SCALE: begin
                w.ld_scale = 1'b1;
            end
            ST_PHASE: begin
                w.wait_out = 1'b1;
                w.ld_out   = 1'b1;
                w.last     = 1'b1;
            end
            default: begin
                w.last = 1'b1;
            end
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/core/pipt_datapath.sv =====
// Datapath of the PI loop filter and phase tracker: shared multiplier,
// integrator, clamp and phase accumulator, driven by control words.
// Depends on pipt_pkg.
module pipt_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pipt_pkg::t_dp_ctl  i_ctl,
    input  logic signed [15:0] i_phase_error,
    input  logic signed [31:0] i_prop_gain,
    input  logic signed [31:0] i_integ_gain,
    input  logic signed [31:0] i_upper_limit,
    input  logic signed [31:0] i_lower_limit,
    input  logic        [31:0] i_time_step,
    output logic        [31:0] o_angle,
    output logic signed [31:0] o_control_out,
    output logic               o_clamped
);
    import pipt_pkg::*;

    logic signed [63:0] r_prod;
    logic signed [32:0] r_up;
    logic signed [31:0] r_integ;
    logic signed [31:0] r_ctl;
    logic               r_hit;
    logic        [31:0] r_phase;
    logic signed [31:0] r_o_ctl;
    logic               r_o_hit;

    logic signed [33:0] mul_a;
    logic signed [33:0] mul_b;
    logic signed [67:0] mul_p;
    logic signed [32:0] up_c;
    logic signed [47:0] integ_inc;
    logic signed [48:0] integ_sum;
    logic signed [31:0] n_integ;
    logic signed [33:0] presat;
    logic signed [33:0] lim_hi;
    logic signed [33:0] lim_lo;
    logic signed [31:0] n_ctl;
    logic               n_hit;
    logic        [47:0] scale_in;
    logic        [47:0] n_scaled;

    // up = floor(prop_gain * err / 2^15), kept 33 bits wide
    assign up_c = r_prod[47:15];

    // Shared multiplier operands
    always_comb begin
        unique case (i_ctl.mul_a)
            MA_PROP:  mul_a = {{2{i_prop_gain[31]}}, i_prop_gain};
            MA_INTEG: mul_a = {{2{i_integ_gain[31]}}, i_integ_gain};
            MA_TSTEP: mul_a = {2'b00, i_time_step};
            default:  mul_a = '0;
        endcase
        unique case (i_ctl.mul_b)
            MB_ERR:  mul_b = {{18{i_phase_error[15]}}, i_phase_error};
            MB_UP:   mul_b = {up_c[32], up_c};
            MB_FREQ: mul_b = {{2{r_ctl[31]}}, r_ctl} + ONE_Q16;
            default: mul_b = '0;
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Integrator update, saturating at the signed 32-bit range
    assign integ_inc = r_prod[63:16];
    assign integ_sum = {{17{r_integ[31]}}, r_integ} + {integ_inc[47], integ_inc};

    always_comb begin
        if (integ_sum[48:31] != {18{integ_sum[48]}}) begin
            n_integ = integ_sum[48] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            n_integ = integ_sum[31:0];
        end
    end

    // Output clamp; upper test first so crossed limits favour the upper one
    assign presat = {r_up[32], r_up} + {{2{r_integ[31]}}, r_integ};
    assign lim_hi = {{2{i_upper_limit[31]}}, i_upper_limit};
    assign lim_lo = {{2{i_lower_limit[31]}}, i_lower_limit};

    always_comb begin
        priority if (presat > lim_hi) begin
            n_ctl = i_upper_limit;
            n_hit = 1'b1;
        end else if (presat < lim_lo) begin
            n_ctl = i_lower_limit;
            n_hit = 1'b1;
        end else begin
            n_ctl = presat[31:0];
            n_hit = 1'b0;
        end
    end

    // x50 by shift and add, low 48 bits only are needed
    assign scale_in = r_prod[47:0];
    assign n_scaled = (scale_in << 5) + (scale_in << 4) + (scale_in << 1);

    // Working registers
    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_scale) begin
            r_prod <= {16'h0000, n_scaled};
        end else if (i_ctl.ld_prod) begin
            r_prod <= mul_p[63:0];
        end
        if (i_ctl.ld_up) begin
            r_up <= up_c;
        end
        if (i_ctl.ld_clamp) begin
            r_ctl <= n_ctl;
            r_hit <= n_hit;
        end
        if (i_ctl.ld_out) begin
            r_o_ctl <= r_ctl;
            r_o_hit <= r_hit;
        end
    end

    // Loop state: integrator and phase accumulator
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ <= '0;
            r_phase <= '0;
        end else begin
            if (i_ctl.ld_integ) begin
                r_integ <= n_integ;
            end
            if (i_ctl.ld_out) begin
                r_phase <= r_phase + r_prod[47:16];
            end
        end
    end

    assign o_angle       = r_phase;
    assign o_control_out = r_o_ctl;
    assign o_clamped     = r_o_hit;

endmodule

// ===== rtl/core/pi_pll_phase_tracker.sv =====
// PI loop filter and phase accumulator of a grid phase-locked loop.
// The input is stalled outside the first step, so a new input is taken only once the
// seven-step program through the one shared multiplier has run back to its start.
// A new input is taken while a finished result still waits in the output
// register; the last step holds until that register is free.
// Synchronous active-low reset: registers to defaults, integrator and angle 0;
// the input is stalled while reset is held.
module pi_pll_phase_tracker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Input channel
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic signed [15:0]                i_phase_error,
    // Output channel
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic        [31:0]                o_angle,
    output logic signed [31:0]                o_control_out,
    output logic                              o_clamped,
    // Configuration write port
    input  logic                              i_cfg_we,
    input  logic        [pipt_pkg::CfgIdxW-1:0] i_cfg_index,
    input  logic        [31:0]                i_cfg_data
);
    import pipt_pkg::*;

    logic [StepW-1:0]   r_step;
    logic [StepW-1:0]   n_step;
    logic               r_o_valid;
    logic               n_o_valid;
    logic signed [31:0] r_prop_gain;
    logic signed [31:0] r_integ_gain;
    logic signed [31:0] r_upper_limit;
    logic signed [31:0] r_lower_limit;
    logic        [31:0] r_time_step;

    t_uop    uop;
    t_dp_ctl dp_ctl;
    logic    in_xact;
    logic    out_xact;
    logic    out_free;
    logic    hold;
    logic    go;

    // Handshakes
    assign o_stall  = !i_rst_n || (r_step != ST_ACCEPT);
    assign in_xact  = i_valid && !o_stall;
    assign out_xact = r_o_valid && !i_stall;
    assign out_free = !r_o_valid || !i_stall;

    // Sequencer: fetch, conditional hold, advance or jump back
    assign uop  = ucode(r_step);
    assign hold = (uop.wait_in && !in_xact) || (uop.wait_out && !out_free);
    assign go   = !hold;

    always_comb begin
        n_step = r_step;
        if (go) begin
            n_step = uop.last ? ST_ACCEPT : r_step + 1'b1;
        end
    end

    // Control bundle, enables gated by the hold condition
    always_comb begin
        dp_ctl.mul_a    = uop.mul_a;
        dp_ctl.mul_b    = uop.mul_b;
        dp_ctl.ld_prod  = uop.ld_prod && go;
        dp_ctl.ld_up    = uop.ld_up && go;
        dp_ctl.ld_integ = uop.ld_integ && go;
        dp_ctl.ld_clamp = uop.ld_clamp && go;
        dp_ctl.ld_scale = uop.ld_scale && go;
        dp_ctl.ld_out   = uop.ld_out && go;
    end

    // Output valid: set on result load, cleared when taken
    always_comb begin
        n_o_valid = r_o_valid;
        if (dp_ctl.ld_out) begin
            n_o_valid = 1'b1;
        end else if (out_xact) begin
            n_o_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step    <= ST_ACCEPT;
            r_o_valid <= 1'b0;
        end else begin
            r_step    <= n_step;
            r_o_valid <= n_o_valid;
        end
    end

    // Configuration registers; unknown indexes are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prop_gain   <= PROP_GAIN_RST;
            r_integ_gain  <= INTEG_GAIN_RST;
            r_upper_limit <= UPPER_LIMIT_RST;
            r_lower_limit <= LOWER_LIMIT_RST;
            r_time_step   <= TIME_STEP_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_PROP_GAIN:   r_prop_gain   <= i_cfg_data;
                CFG_INTEG_GAIN:  r_integ_gain  <= i_cfg_data;
                CFG_UPPER_LIMIT: r_upper_limit <= i_cfg_data;
                CFG_LOWER_LIMIT: r_lower_limit <= i_cfg_data;
                CFG_TIME_STEP:   r_time_step   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    pipt_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (dp_ctl),
        .i_phase_error (i_phase_error),
        .i_prop_gain   (r_prop_gain),
        .i_integ_gain  (r_integ_gain),
        .i_upper_limit (r_upper_limit),
        .i_lower_limit (r_lower_limit),
        .i_time_step   (r_time_step),
        .o_angle       (o_angle),
        .o_control_out (o_control_out),
        .o_clamped     (o_clamped)
    );

    assign o_valid = r_o_valid;

endmodule

// ===== tb/sv/tb_pi_pll_phase_tracker.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the PI loop filter and phase tracker.
// Directed table then randomised phases, checked against a cycle-free predictor.
// Depends on pipt_pkg and pi_pll_phase_tracker only.
module tb_pi_pll_phase_tracker;
    import pipt_pkg::*;

    localparam int LATENCY        = 7;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int N_PHASES       = 8;
    localparam int PHASE_ITEMS    = 150;
    localparam int CALM_PHASE     = 3;
    localparam int PRESSURE_PHASE = 5;
    localparam int DIR_N          = 21;

    // One complete register set
    typedef struct packed {
        logic [31:0] kp;
        logic [31:0] ki;
        logic [31:0] hi;
        logic [31:0] lo;
        logic [31:0] ts;
    } t_cfg_set;

    // One result transaction
    typedef struct packed {
        logic        [31:0] angle;
        logic signed [31:0] ctl;
        logic               clamped;
    } t_pll_out;

    // How much of a directed row's result is typed in the table
    typedef enum logic [1:0] {
        CHK_PRED = 2'd0,  // all fields from the predictor
        CHK_CTL  = 2'd1,  // control_out and clamped typed, angle predicted
        CHK_ALL  = 2'd2   // every field typed
    } t_chk;

    typedef struct packed {
        int                 cfg_sel;  // -1 keeps the current registers
        logic signed [15:0] err;
        t_chk               chk;
        logic        [31:0] angle;
        logic signed [31:0] ctl;
        logic               clamped;
    } t_dir_row;

    // Register sets used by the directed part
    localparam t_cfg_set DIR_CFG [6] = '{
        // proportional gain at its maximum
        '{32'h7FFF_FFFF, 32'h0000_0000, 32'h0001_0000, 32'hFFFF_0000, 32'd429497},
        // both gains at their minimum, widest limits, longest step
        '{32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF},
        // crossed limits
        '{32'h0001_0000, 32'h0000_0000, 32'hFFFF_0000, 32'h0001_0000, 32'd429497},
        // room for a negative frequency
        '{32'h0004_0000, 32'h0000_0000, 32'h0001_0000, 32'hFFFC_0000, 32'd429497},
        // increment of a whole number of turns
        '{32'h0001_0000, 32'h0000_0000, 32'h7FFF_0000, 32'h7FFF_0000, 32'h0002_0000},
        // integral gain at its maximum, zero step
        '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000}
    };

    localparam t_dir_row DIR_ROWS [DIR_N] = '{
        '{-1, 16'sd0,     CHK_ALL,  32'd21474850, 32'sd0,         1'b0},
        '{-1, 16'sh7FFF,  CHK_PRED, 32'd0,        32'sd0,         1'b0},
        '{-1, 16'sh8000,  CHK_CTL,  32'd0,        -32'sd65536,    1'b0},
        '{-1, 16'sd16384, CHK_PRED, 32'd0,        32'sd0,         1'b0},
        '{-1, -16'sd1,    CHK_PRED, 32'd0,        32'sd0,         1'b0},
        '{0,  16'sh7FFF,  CHK_CTL,  32'd0,        32'sd65536,     1'b1},
        '{-1, 16'sh8000,  CHK_CTL,  32'd0,        -32'sd65536,    1'b1},
        '{-1, 16'sd0,     CHK_CTL,  32'd0,        32'sd0,         1'b0},
        '{1,  16'sh8000,  CHK_PRED, 32'd0,        32'sd0,         1'b0},
        '{-1, 16'sh7FFF,  CHK_PRED, 32'd0,        32'sd0,         1'b0},
        '{-1, 16'sd1,     CHK_PRED, 32'd0,        32'sd0,         1'b0},
        '{-1, -16'sd1,    CHK_PRED, 32'd0,        32'sd0,         1'b0},
        // integrator sits at -1 from here; crossed limits, upper test wins
        '{2,  16'sd0,     CHK_CTL,  32'd0,        -32'sd65536,    1'b1},
        '{-1, 16'sh8000,  CHK_CTL,  32'd0,        32'sd65536,     1'b1},
        '{3,  16'sh8000,  CHK_CTL,  32'd0,        -32'sd262144,   1'b1},
        '{-1, 16'sh8000,  CHK_PRED, 32'd0,        32'sd0,         1'b0},
        '{-1, 16'sh7FFF,  CHK_PRED, 32'd0,        32'sd0,         1'b0},
        '{4,  16'sd12345, CHK_CTL,  32'd0,        32'sh7FFF_0000, 1'b1},
        '{5,  16'sh7FFF,  CHK_CTL,  32'd0,        32'sh7FFF_FFFF, 1'b1},
        '{-1, 16'sh8000,  CHK_PRED, 32'd0,        32'sd0,         1'b0},
        '{-1, 16'sd0,     CHK_PRED, 32'd0,        32'sd0,         1'b0}
    };

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_valid;
    logic                      o_stall;
    logic signed [15:0]        i_phase_error;
    logic                      o_valid;
    logic                      i_stall;
    logic        [31:0]        o_angle;
    logic signed [31:0]        o_control_out;
    logic                      o_clamped;
    logic                      i_cfg_we;
    logic        [CfgIdxW-1:0] i_cfg_index;
    logic        [31:0]        i_cfg_data;

    // Predictor state
    t_cfg_set    cur_cfg;
    longint      integ_acc;
    logic [31:0] phase_acc;

    t_pll_out predicted_out [$];
    int       mismatch_cnt = 0;
    bit       hold_req     = 1'b0;
    bit       calm         = 1'b0;

    pi_pll_phase_tracker u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_phase_error (i_phase_error),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_angle       (o_angle),
        .o_control_out (o_control_out),
        .o_clamped     (o_clamped),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Loop filter and phase accumulator for one error sample
    function automatic t_pll_out track_sample(input logic signed [15:0] err);
        longint      prop;
        longint      incr;
        longint      presat;
        longint      ctl;
        logic [63:0] freq;
        logic [63:0] span;
        t_pll_out    r;
        prop = (longint'(signed'(cur_cfg.kp)) * longint'(err)) >>> 15;
        incr = (longint'(signed'(cur_cfg.ki)) * prop) >>> 16;
        integ_acc = integ_acc + incr;
        if (integ_acc > 64'sd2147483647)
            integ_acc = 64'sd2147483647;
        else if (integ_acc < -64'sd2147483648)
            integ_acc = -64'sd2147483648;
        presat = prop + integ_acc;
        r.clamped = 1'b1;
        if (presat > longint'(signed'(cur_cfg.hi))) begin
            ctl = longint'(signed'(cur_cfg.hi));
        end else if (presat < longint'(signed'(cur_cfg.lo))) begin
            ctl = longint'(signed'(cur_cfg.lo));
        end else begin
            ctl = presat;
            r.clamped = 1'b0;
        end
        // per-unit frequency times step, modulo 2^64; bits 47:16 are the turn fraction
        freq = ctl + 64'sd65536;
        span = {32'd0, cur_cfg.ts} * freq * 64'd50;
        phase_acc = phase_acc + span[47:16];
        r.angle = phase_acc;
        r.ctl = ctl[31:0];
        return r;
    endfunction

    function automatic logic [31:0] pick_reg(input logic [31:0] usual,
                                             input logic [31:0] lo_ext,
                                             input logic [31:0] hi_ext,
                                             input bit wild);
        if (!wild)
            return usual;
        unique case ($urandom_range(3))
            0: return lo_ext;
            1: return hi_ext;
            2: return $urandom();
            default: return usual;
        endcase
    endfunction

    function automatic logic [31:0] vary_sign(input logic [31:0] mag);
        return ($urandom_range(4) == 0) ? -mag : mag;
    endfunction

    function automatic logic signed [15:0] pick_error();
        unique case ($urandom_range(9))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2, 3: return 16'($urandom_range(400)) - 16'sd200;
            default: return 16'($urandom());
        endcase
    endfunction

    // Offer one sample; returns at the edge where the transaction is taken
    task automatic offer_sample(input logic signed [15:0] err);
        if (!calm) begin
            while ($urandom_range(99) < 37) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_valid       <= 1'b1;
        i_phase_error <= err;
        do begin
            @(posedge i_clk);
        end while (o_stall);
    endtask

    // Stop offering and wait until every result has been taken
    task automatic quiesce();
        i_valid <= 1'b0;
        while (predicted_out.size() != 0)
            @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
    endtask

    // Write all five registers back to back, then a spare index that must be ignored
    task automatic load_settings(input t_cfg_set s);
        logic [CfgIdxW-1:0] idx [6];
        logic [31:0]        val [6];
        idx = '{CFG_PROP_GAIN, CFG_INTEG_GAIN, CFG_UPPER_LIMIT, CFG_LOWER_LIMIT,
                CFG_TIME_STEP, CfgIdxW'($urandom_range(2**CfgIdxW - 1, CFG_TIME_STEP + 1))};
        val = '{s.kp, s.ki, s.hi, s.lo, s.ts, $urandom()};
        for (int k = 0; k < 6; k++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= idx[k];
            i_cfg_data  <= val[k];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        cur_cfg = s;
    endtask

    // Receiver: random stalls, a calm stretch, and one long hold-off
    initial begin
        int hold_cnt;
        i_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_stall <= 1'b1;
                for (hold_cnt = 0; hold_cnt < HOLD_CYCLES; hold_cnt++)
                    @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                i_stall <= !calm && ($urandom_range(99) < 37);
            end
        end
    end

    // Result checking against the oldest prediction
    always @(posedge i_clk) begin : check_results
        t_pll_out want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (predicted_out.size() == 0) begin
                $error("result transaction with nothing expected");
                mismatch_cnt++;
            end else begin
                want = predicted_out.pop_front();
                if (o_angle !== want.angle) begin
                    $error("angle: expected %h, got %h", want.angle, o_angle);
                    mismatch_cnt++;
                end
                if (o_control_out !== want.ctl) begin
                    $error("control_out: expected %0d, got %0d", want.ctl, o_control_out);
                    mismatch_cnt++;
                end
                if (o_clamped !== want.clamped) begin
                    $error("clamped: expected %b, got %b", want.clamped, o_clamped);
                    mismatch_cnt++;
                end
            end
        end
    end

    // Watchdog on cycles without any transaction
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // Stimulus
    initial begin
        t_pll_out           res;
        t_cfg_set           s;
        logic signed [15:0] err;
        bit                 wild;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_phase_error = '0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        cur_cfg   = '{PROP_GAIN_RST, INTEG_GAIN_RST, UPPER_LIMIT_RST, LOWER_LIMIT_RST,
                      TIME_STEP_RST};
        integ_acc = 0;
        phase_acc = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table
        for (int r = 0; r < DIR_N; r++) begin
            if (DIR_ROWS[r].cfg_sel >= 0) begin
                quiesce();
                load_settings(DIR_CFG[DIR_ROWS[r].cfg_sel]);
            end
            offer_sample(DIR_ROWS[r].err);
            res = track_sample(DIR_ROWS[r].err);
            if (DIR_ROWS[r].chk != CHK_PRED) begin
                res.ctl     = DIR_ROWS[r].ctl;
                res.clamped = DIR_ROWS[r].clamped;
            end
            if (DIR_ROWS[r].chk == CHK_ALL)
                res.angle = DIR_ROWS[r].angle;
            predicted_out.push_back(res);
        end

        // Random phases, odd ones with registers pushed to their extremes
        for (int p = 0; p < N_PHASES; p++) begin
            quiesce();
            wild = p[0];
            s.kp = pick_reg(vary_sign($urandom_range(4 * 65536)),
                            32'h8000_0000, 32'h7FFF_FFFF, wild);
            s.ki = pick_reg(vary_sign($urandom_range(16384)),
                            32'h8000_0000, 32'h7FFF_FFFF, wild);
            s.hi = pick_reg($urandom_range(4 * 65536, 8192),
                            32'h8000_0000, 32'h7FFF_FFFF, wild);
            s.lo = pick_reg(-$urandom_range(4 * 65536, 8192),
                            32'h8000_0000, 32'h7FFF_FFFF, wild);
            s.ts = pick_reg($urandom_range(1000000, 100000),
                            32'h0000_0000, 32'hFFFF_FFFF, wild);
            load_settings(s);
            calm = (p == CALM_PHASE);
            if (p == PRESSURE_PHASE)
                hold_req = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                err = pick_error();
                offer_sample(err);
                predicted_out.push_back(track_sample(err));
            end
        end
        quiesce();

        if (mismatch_cnt == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
